>>> hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define BRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define BRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/bra_pkg.sv
// Shared constants, types and helpers of the banker's resource allocator
`default_nettype none
package bra_pkg;

  localparam int CUSTOMERS     = 5;
  localparam int RESOURCES     = 4;
  localparam int COUNT_BITS    = 8;

  localparam int ROW_REGS      = 5;
  localparam int AMOUNT_FIELDS = 4;
  localparam int AMT_BITS      = 8;
  localparam int CUST_BITS     = 3;
  localparam int STATUS_BITS   = 3;
  localparam int CFG_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int LANE_CNT_BITS = 3;

  localparam int LANES_MAX = (RESOURCES < AMOUNT_FIELDS) ? RESOURCES : AMOUNT_FIELDS;
  localparam int CIDX_BITS = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int WORK_BITS = COUNT_BITS + $clog2(CUSTOMERS + 1);
  localparam int EXT_BITS  = (WORK_BITS > AMT_BITS) ? WORK_BITS : AMT_BITS;

  typedef logic [COUNT_BITS-1:0]                    count_t;
  typedef logic [WORK_BITS-1:0]                     work_t;
  typedef logic [EXT_BITS-1:0]                      ext_t;
  typedef logic [CIDX_BITS-1:0]                     cidx_t;
  typedef count_t [RESOURCES-1:0]                   row_t;
  typedef work_t [RESOURCES-1:0]                    work_vec_t;
  typedef logic [RESOURCES-1:0]                     lane_mask_t;
  typedef logic [AMOUNT_FIELDS-1:0][AMT_BITS-1:0]   amt_fields_t;
  typedef logic [ROW_REGS-1:0][CFG_BITS-1:0]        claim_regs_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK         = 3'd0,
    STAT_NEED_OVER  = 3'd1,
    STAT_AVAIL_OVER = 3'd2,
    STAT_UNSAFE     = 3'd3,
    STAT_REL_OVER   = 3'd4
  } status_t;

  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_ROW_0  = 3'd0,
    CFG_MAX_ROW_1  = 3'd1,
    CFG_MAX_ROW_2  = 3'd2,
    CFG_MAX_ROW_3  = 3'd3,
    CFG_MAX_ROW_4  = 3'd4,
    CFG_INIT_AVAIL = 3'd5,
    CFG_LANES      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic        reload;
    lane_mask_t  lane_en;
    logic [CFG_BITS-1:0] init_avail;
    claim_regs_t max_row;
  } cfg_view_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic eval_scan;
    logic scan_end;
  } dp_sts_t;

  function automatic count_t lane_of(input logic [CFG_BITS-1:0] word_v, input int r);
    logic [CFG_BITS-1:0] s;
    s = word_v >> (r * COUNT_BITS);
    return s[COUNT_BITS-1:0];
  endfunction

  function automatic count_t claim_of(input claim_regs_t rows, input int c, input int r);
    logic [ROW_REGS*CFG_BITS-1:0] s;
    s = rows >> (c * CFG_BITS);
    return lane_of(s[CFG_BITS-1:0], r);
  endfunction

  function automatic logic [AMT_BITS-1:0] amount_lane(input amt_fields_t f, input int r);
    logic [AMOUNT_FIELDS*AMT_BITS-1:0] s;
    s = f >> (r * AMT_BITS);
    return s[AMT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/bra_cfg.sv
// Configuration registers, lane mask and state reload values
`default_nettype none
module bra_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bra_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bra_pkg::CFG_BITS-1:0]   cfg_wdata,
  output bra_pkg::cfg_view_t             cfg
);
  import bra_pkg::*;

  claim_regs_t                max_row_r, max_row_nxt;
  logic [CFG_BITS-1:0]        init_avail_r, init_avail_nxt;
  logic [LANE_CNT_BITS-1:0]   lanes_r, lanes_nxt;
  logic [LANE_CNT_BITS-1:0]   lanes_n;
  logic                       hit;

  always_comb begin
    max_row_nxt    = max_row_r;
    init_avail_nxt = init_avail_r;
    lanes_nxt      = lanes_r;
    hit            = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        CFG_MAX_ROW_0, CFG_MAX_ROW_1, CFG_MAX_ROW_2, CFG_MAX_ROW_3, CFG_MAX_ROW_4: begin
          max_row_nxt[cfg_index] = cfg_wdata;
          hit = 1'b1;
        end
        CFG_INIT_AVAIL: begin
          init_avail_nxt = cfg_wdata;
          hit = 1'b1;
        end
        CFG_LANES: begin
          lanes_nxt = cfg_wdata[LANE_CNT_BITS-1:0];
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_row_r    <= '0;
      init_avail_r <= '0;
      lanes_r      <= LANE_CNT_BITS'(4);
    end else begin
      max_row_r    <= max_row_nxt;
      init_avail_r <= init_avail_nxt;
      lanes_r      <= lanes_nxt;
    end
  end

  always_comb begin
    if (lanes_r == '0) begin
      lanes_n = LANE_CNT_BITS'(1);
    end else if (32'(lanes_r) > LANES_MAX) begin
      lanes_n = LANE_CNT_BITS'(LANES_MAX);
    end else begin
      lanes_n = lanes_r;
    end
    for (int r = 0; r < RESOURCES; r++) begin
      cfg.lane_en[r] = (r < 32'(lanes_n));
    end
    cfg.reload     = hit;
    cfg.init_avail = init_avail_nxt;
    cfg.max_row    = max_row_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/bra_ctrl.sv
// Sequencing state machine of the allocator
`default_nettype none
module bra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bra_pkg::dp_cmd_t  cmd,
  input  bra_pkg::dp_sts_t  sts
);
  import bra_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.eval_scan ? ST_SCAN : ST_POST;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hdl/bra_dp.sv
// Allocation state, request checks, safety scan and result register
`default_nettype none
module bra_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bra_pkg::dp_cmd_t                  cmd,
  output bra_pkg::dp_sts_t                  sts,
  input  bra_pkg::cfg_view_t                cfg,
  input  logic                              in_func,
  input  logic [bra_pkg::CUST_BITS-1:0]     in_customer,
  input  bra_pkg::amt_fields_t              in_amount,
  output logic                              out_granted,
  output logic [bra_pkg::STATUS_BITS-1:0]   out_status
);
  import bra_pkg::*;

  func_t                    func_r, func_nxt;
  logic [CUST_BITS-1:0]     cust_r, cust_nxt;
  amt_fields_t              amt_r, amt_nxt;
  row_t                     avail_r, avail_nxt;
  row_t [CUSTOMERS-1:0]     alloc_r, alloc_nxt, need_r, need_nxt;
  row_t                     cust_alloc_r, cust_alloc_nxt, cust_need_r, cust_need_nxt;
  work_vec_t                work_r, work_nxt, work_add, work_init;
  logic [CUSTOMERS-1:0]     done_r, done_nxt, done_scan;
  cidx_t                    scan_idx_r, scan_idx_nxt, pass_r, pass_nxt;
  logic                     progress_r, progress_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic                     out_granted_r, out_granted_nxt;
  status_t                  out_status_r, out_status_nxt;

  cidx_t                    cust_idx, rd_idx;
  logic                     cust_ok, is_cust;
  row_t                     rd_alloc, rd_need, adj_alloc, adj_need;
  row_t                     rel_alloc, rel_need, rel_avail;
  row_t                     req_alloc, req_need, req_avail, init_avail_row;
  row_t [CUSTOMERS-1:0]     claim_rows;
  ext_t [RESOURCES-1:0]     amt_ext;
  logic                     over_alloc, over_need, over_avail, fits, take, prog;
  logic                     last_row, last_pass, all_done, release_ok, eval_scan, scan_end;
  status_t                  eval_status;

  assign cust_idx = cidx_t'(cust_r);
  assign cust_ok  = (32'(cust_r) < CUSTOMERS);
  assign rd_idx   = cmd.scan ? scan_idx_r : cust_idx;
  assign rd_alloc = alloc_r[rd_idx];
  assign rd_need  = need_r[rd_idx];
  assign is_cust  = (scan_idx_r == cust_idx);

  always_comb begin
    over_alloc = 1'b0;
    over_need  = 1'b0;
    over_avail = 1'b0;
    fits       = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      amt_ext[r] = EXT_BITS'(amount_lane(amt_r, r));
      if (cfg.lane_en[r] && amt_ext[r] > EXT_BITS'(rd_alloc[r])) over_alloc = 1'b1;
      if (cfg.lane_en[r] && amt_ext[r] > EXT_BITS'(rd_need[r]))  over_need  = 1'b1;
      if (cfg.lane_en[r] && amt_ext[r] > EXT_BITS'(avail_r[r]))  over_avail = 1'b1;

      rel_alloc[r] = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(rd_alloc[r]) - amt_ext[r]) : rd_alloc[r];
      rel_need[r]  = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(rd_need[r]) + amt_ext[r]) : rd_need[r];
      rel_avail[r] = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(avail_r[r]) + amt_ext[r]) : avail_r[r];
      req_alloc[r] = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(cust_alloc_r[r]) + amt_ext[r]) : cust_alloc_r[r];
      req_need[r]  = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(cust_need_r[r]) - amt_ext[r]) : cust_need_r[r];
      req_avail[r] = cfg.lane_en[r] ?
                     count_t'(EXT_BITS'(avail_r[r]) - amt_ext[r]) : avail_r[r];

      adj_alloc[r] = is_cust ? req_alloc[r] : rd_alloc[r];
      adj_need[r]  = is_cust ? req_need[r]  : rd_need[r];
      if (cfg.lane_en[r] && EXT_BITS'(adj_need[r]) > EXT_BITS'(work_r[r])) fits = 1'b0;
      work_add[r]  = cfg.lane_en[r] ?
                     work_t'(EXT_BITS'(work_r[r]) + EXT_BITS'(adj_alloc[r])) : work_r[r];
      work_init[r] = work_t'(req_avail[r]);

      init_avail_row[r] = lane_of(cfg.init_avail, r);
      for (int c = 0; c < CUSTOMERS; c++) begin
        claim_rows[c][r] = (c < ROW_REGS) ? claim_of(cfg.max_row, c, r) : '0;
      end
    end
  end

  always_comb begin
    if (func_r == FUNC_RELEASE) begin
      eval_status = (!cust_ok || over_alloc) ? STAT_REL_OVER : STAT_OK;
    end else if (!cust_ok || over_need) begin
      eval_status = STAT_NEED_OVER;
    end else if (over_avail) begin
      eval_status = STAT_AVAIL_OVER;
    end else begin
      eval_status = STAT_OK;
    end
    release_ok = (func_r == FUNC_RELEASE) && (eval_status == STAT_OK);
    eval_scan  = (func_r == FUNC_REQUEST) && (eval_status == STAT_OK);

    take      = !done_r[scan_idx_r] && fits;
    done_scan = done_r;
    if (take) done_scan[scan_idx_r] = 1'b1;
    prog      = progress_r || take;
    last_row  = (scan_idx_r == cidx_t'(CUSTOMERS - 1));
    last_pass = (pass_r == cidx_t'(CUSTOMERS - 1));
    all_done  = &done_scan;
    scan_end  = last_row && (all_done || !prog || last_pass);
  end

  assign sts.eval_scan = eval_scan;
  assign sts.scan_end  = scan_end;

  always_comb begin
    func_nxt        = func_r;
    cust_nxt        = cust_r;
    amt_nxt         = amt_r;
    avail_nxt       = avail_r;
    alloc_nxt       = alloc_r;
    need_nxt        = need_r;
    cust_alloc_nxt  = cust_alloc_r;
    cust_need_nxt   = cust_need_r;
    work_nxt        = work_r;
    done_nxt        = done_r;
    scan_idx_nxt    = scan_idx_r;
    pass_nxt        = pass_r;
    progress_nxt    = progress_r;
    res_status_nxt  = res_status_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;

    if (cmd.load) begin
      func_nxt = func_t'(in_func);
      cust_nxt = in_customer;
      amt_nxt  = in_amount;
    end

    if (cmd.eval) begin
      res_status_nxt = eval_status;
      cust_alloc_nxt = rd_alloc;
      cust_need_nxt  = rd_need;
      if (release_ok) begin
        avail_nxt           = rel_avail;
        alloc_nxt[cust_idx] = rel_alloc;
        need_nxt[cust_idx]  = rel_need;
      end
      if (eval_scan) begin
        work_nxt     = work_init;
        done_nxt     = '0;
        scan_idx_nxt = '0;
        pass_nxt     = '0;
        progress_nxt = 1'b0;
      end
    end

    if (cmd.scan) begin
      done_nxt = done_scan;
      if (take) work_nxt = work_add;
      if (!last_row) begin
        scan_idx_nxt = cidx_t'(scan_idx_r + 1'b1);
        progress_nxt = prog;
      end else if (all_done) begin
        res_status_nxt      = STAT_OK;
        avail_nxt           = req_avail;
        alloc_nxt[cust_idx] = req_alloc;
        need_nxt[cust_idx]  = req_need;
      end else if (!prog || last_pass) begin
        res_status_nxt = STAT_UNSAFE;
      end else begin
        scan_idx_nxt = '0;
        pass_nxt     = cidx_t'(pass_r + 1'b1);
        progress_nxt = 1'b0;
      end
    end

    if (cmd.publish) begin
      out_granted_nxt = (res_status_r == STAT_OK);
      out_status_nxt  = res_status_r;
    end

    if (cfg.reload) begin
      avail_nxt = init_avail_row;
      alloc_nxt = '0;
      need_nxt  = claim_rows;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r      <= '0;
      alloc_r      <= '0;
      need_r       <= '0;
      done_r       <= '0;
      scan_idx_r   <= '0;
      pass_r       <= '0;
      progress_r   <= 1'b0;
      res_status_r <= STAT_OK;
    end else begin
      avail_r      <= avail_nxt;
      alloc_r      <= alloc_nxt;
      need_r       <= need_nxt;
      done_r       <= done_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pass_r       <= pass_nxt;
      progress_r   <= progress_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    cust_r        <= cust_nxt;
    amt_r         <= amt_nxt;
    cust_alloc_r  <= cust_alloc_nxt;
    cust_need_r   <= cust_need_nxt;
    work_r        <= work_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_granted = out_granted_r;
  assign out_status  = out_status_r;

endmodule
`default_nettype wire

>>> hdl/bankers_resource_allocator.sv
// Top level of the banker's resource allocator
// Takes one request or release transaction of up to four resource counts for one
// customer and returns one result: granted plus a status code. A release, or a
// request refused for exceeding need or availability, gives its result once it
// has passed the load, evaluate and publish states. A request that passes those
// checks runs the banker's safety test, which visits one customer row per cycle
// over at most CUSTOMERS passes before its result is published; that row scan
// sets the rate. One transaction is in work at a time; the next is accepted
// while the previous result waits in the output register. Any write to a defined
// configuration register reloads available units and remaining need and clears
// all allocations; write configuration only while idle.
`default_nettype none
`include "assert_macros.svh"
module bankers_resource_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [bra_pkg::CUST_BITS-1:0]      in_customer,
  input  logic [bra_pkg::AMT_BITS-1:0]       in_amount_0,
  input  logic [bra_pkg::AMT_BITS-1:0]       in_amount_1,
  input  logic [bra_pkg::AMT_BITS-1:0]       in_amount_2,
  input  logic [bra_pkg::AMT_BITS-1:0]       in_amount_3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_granted,
  output logic [bra_pkg::STATUS_BITS-1:0]    out_status,
  input  logic                               cfg_we,
  input  logic [bra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bra_pkg::CFG_BITS-1:0]       cfg_wdata
);
  import bra_pkg::*;

  cfg_view_t   cfg;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  amt_fields_t amounts;

  assign amounts = {in_amount_3, in_amount_2, in_amount_1, in_amount_0};

  bra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bra_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .in_func     (in_func),
    .in_customer (in_customer),
    .in_amount   (amounts),
    .out_granted (out_granted),
    .out_status  (out_status)
  );

  `BRA_ASSERT(a_grant_matches_status, clk, rst_n, out_valid |-> (out_granted == (out_status == STAT_OK)), "granted disagrees with status")
  `BRA_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "input not stalled after accept")
  `BRA_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid && !in_stall), "reset left block busy")

endmodule
`default_nettype wire
